FILE: sv/csvft_pkg.sv
package csvft_pkg;

  localparam int CHAR_W        = 8;
  localparam int COUNT_W       = 9;
  localparam int COL_IDX_W     = 8;
  localparam int KIND_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 9;
  localparam int MAX_COLUMNS_DEF = 256;

  localparam logic [CHAR_W-1:0]  SEPARATOR_RESET = 8'd44;
  localparam logic [CHAR_W-1:0]  PROTECTOR_RESET = 8'd34;
  localparam logic [COUNT_W-1:0] COLUMN_COUNT_RESET = 9'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_LAST  = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_LONG  = 2'd1,
    STATUS_SHORT = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEPARATOR    = 2'd0,
    REG_PROTECTOR    = 2'd1,
    REG_COLUMN_COUNT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  separator_char;
    logic [CHAR_W-1:0]  protector_char;
    logic [COUNT_W-1:0] column_count;
  } cfg_t;

  typedef struct packed {
    kind_t                kind;
    logic [CHAR_W-1:0]    char_value;
    logic [COL_IDX_W-1:0] column_index;
    logic                 was_protected;
    logic                 was_empty;
    status_t              status;
  } result_t;

endpackage

FILE: sv/csvft_if.sv
interface csvft_byte_if;
  import csvft_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] data_byte;
  logic              line_end;
  modport source(output valid, data_byte, line_end, input ready);
  modport sink(input valid, data_byte, line_end, output ready);
endinterface

interface csvft_token_if;
  import csvft_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [CHAR_W-1:0]    char_value;
  logic [COL_IDX_W-1:0] column_index;
  logic                 was_protected;
  logic                 was_empty;
  logic [STATUS_W-1:0]  status;
  modport source(output valid, kind, char_value, column_index, was_protected,
                 was_empty, status, input ready);
  modport sink(input valid, kind, char_value, column_index, was_protected,
               was_empty, status, output ready);
endinterface

interface csvft_cfg_if;
  import csvft_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: sv/csvft_cfg_regs.sv
module csvft_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  csvft_cfg_if.sink     cfg,
  output csvft_pkg::cfg_t regs
);
  import csvft_pkg::*;

  cfg_t regs_q;

  assign cfg.ready = 1'b1;
  assign regs      = regs_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q.separator_char <= SEPARATOR_RESET;
      regs_q.protector_char <= PROTECTOR_RESET;
      regs_q.column_count   <= COLUMN_COUNT_RESET;
    end else if (cfg.valid) begin
      // Writes to an index past the last register are dropped.
      unique case (cfg.index)
        REG_SEPARATOR:    regs_q.separator_char <= cfg.data[CHAR_W-1:0];
        REG_PROTECTOR:    regs_q.protector_char <= cfg.data[CHAR_W-1:0];
        REG_COLUMN_COUNT: regs_q.column_count   <= cfg.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/csvft_core.sv
module csvft_core #(
  parameter int MAX_COLUMNS = csvft_pkg::MAX_COLUMNS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [csvft_pkg::CHAR_W-1:0] data_byte,
  input  logic                        line_end,
  input  csvft_pkg::cfg_t             regs,
  output logic                        res_valid,
  output csvft_pkg::result_t          res
);
  import csvft_pkg::*;

  localparam int CW   = $clog2(MAX_COLUMNS + 2);
  localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_COLUMNS + 1);

  logic          inside_text, inside_text_next;
  logic          pending_protector, pending_protector_next;
  logic          closed_last, closed_last_next;
  logic          field_empty, field_empty_next;
  logic [CW-1:0] column_counter, column_counter_next;
  logic          error_sticky, error_sticky_next;

  logic          is_prot, is_sep, literal_prot;
  logic          inside_eff, closed_eff;
  logic [CW-1:0] counter_inc, total;
  status_t       line_status;

  assign is_prot      = (data_byte == regs.protector_char);
  assign is_sep       = (data_byte == regs.separator_char);
  assign literal_prot = pending_protector && !line_end && is_prot;
  // A held protector that is not doubled closes the protected text.
  assign inside_eff   = pending_protector ? 1'b0 : inside_text;
  assign closed_eff   = pending_protector ? 1'b1 : closed_last;
  assign counter_inc  = (column_counter < COUNT_MAX) ? column_counter + 1'b1
                                                     : column_counter;
  assign total        = inside_eff ? column_counter : counter_inc;

  always_comb begin
    if (CMPW'(total) > CMPW'(regs.column_count)) begin
      line_status = STATUS_LONG;
    end else if (CMPW'(total) < CMPW'(regs.column_count)) begin
      line_status = STATUS_SHORT;
    end else begin
      line_status = STATUS_OK;
    end
  end

  always_comb begin
    inside_text_next       = inside_text;
    pending_protector_next = pending_protector;
    closed_last_next       = closed_last;
    field_empty_next       = field_empty;
    column_counter_next    = column_counter;
    error_sticky_next      = error_sticky;
    res_valid              = 1'b0;
    res                    = '0;
    res.kind               = KIND_CHAR;
    res.status             = STATUS_OK;
    if (!error_sticky) begin
      pending_protector_next = 1'b0;
      inside_text_next       = inside_eff;
      closed_last_next       = closed_eff;
      priority if (literal_prot) begin
        inside_text_next  = inside_text;
        closed_last_next  = closed_last;
        field_empty_next  = 1'b0;
        res_valid         = 1'b1;
        res.char_value    = regs.protector_char;
      end else if (line_end) begin
        res_valid           = 1'b1;
        res.kind            = KIND_LAST;
        res.column_index    = COL_IDX_W'(column_counter);
        res.was_protected   = closed_eff;
        res.was_empty       = field_empty;
        res.status          = line_status;
        error_sticky_next   = (line_status != STATUS_OK);
        inside_text_next    = 1'b0;
        closed_last_next    = 1'b0;
        field_empty_next    = 1'b1;
        column_counter_next = '0;
      end else if (!inside_eff && is_sep) begin
        res_valid           = 1'b1;
        res.kind            = KIND_FIELD;
        res.column_index    = COL_IDX_W'(column_counter);
        res.was_protected   = closed_eff;
        res.was_empty       = field_empty;
        column_counter_next = counter_inc;
        closed_last_next    = 1'b0;
        field_empty_next    = 1'b1;
      end else if (is_prot) begin
        if (inside_eff) begin
          pending_protector_next = 1'b1;
        end else begin
          closed_last_next = 1'b0;
          inside_text_next = 1'b1;
        end
      end else begin
        field_empty_next = 1'b0;
        res_valid        = 1'b1;
        res.char_value   = data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_text       <= 1'b0;
      pending_protector <= 1'b0;
      closed_last       <= 1'b0;
      field_empty       <= 1'b1;
      column_counter    <= '0;
      error_sticky      <= 1'b0;
    end else if (accept) begin
      inside_text       <= inside_text_next;
      pending_protector <= pending_protector_next;
      closed_last       <= closed_last_next;
      field_empty       <= field_empty_next;
      column_counter    <= column_counter_next;
      error_sticky      <= error_sticky_next;
    end
  end

endmodule

FILE: sv/csvft_out_reg.sv
module csvft_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               res_valid,
  input  csvft_pkg::result_t res,
  output logic               can_load,
  csvft_token_if.source      tokens
);
  import csvft_pkg::*;

  logic    valid;
  result_t data;

  // A new word may enter when no word is held or the held one leaves in the same cycle.
  assign can_load = !valid || tokens.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= res_valid;
    end else if (tokens.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign tokens.valid         = valid;
  assign tokens.kind          = data.kind;
  assign tokens.char_value    = data.char_value;
  assign tokens.column_index  = data.column_index;
  assign tokens.was_protected = data.was_protected;
  assign tokens.was_empty     = data.was_empty;
  assign tokens.status        = data.status;

endmodule

FILE: sv/csv_field_tokenizer_unit.sv
// Splits a line of delimited text into fields at one byte per clock. Each
// accepted byte word gives at most one token word: a content character, a
// field end (column index, closed-by-protection flag, empty flag) or, for the
// line-end word, the last field end with the line status against the
// configured column count. A new byte is taken every cycle as long as the
// token register is free or being emptied. A protector inside protected
// text is held and resolved by the next word, so it produces its token one
// word later. After a line with a bad column count every further word is
// consumed without output until reset. Configuration registers must be
// written only while the block is idle; the block does not enforce this.
module csv_field_tokenizer_unit #(
  parameter int MAX_COLUMNS = csvft_pkg::MAX_COLUMNS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  csvft_byte_if.sink    bytes,
  csvft_token_if.source tokens,
  csvft_cfg_if.sink     cfg
);
  import csvft_pkg::*;

  cfg_t    regs;
  result_t res;
  logic    res_valid;
  logic    can_load;
  logic    accept;

  assign bytes.ready = can_load;
  assign accept      = bytes.valid && can_load;

  csvft_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  csvft_core #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (bytes.data_byte),
    .line_end  (bytes.line_end),
    .regs      (regs),
    .res_valid (res_valid),
    .res       (res)
  );

  csvft_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .tokens    (tokens)
  );

endmodule
